// ----- hw/rtl/alvp_pkg.sv -----
// ----------------------------------------------------------------------------
// alvp_pkg: shared types, constants and tables for the label vote block
// Holds the map and label sizes, the fixed-point formats, the configuration
// register map, the divider stage record and the log and ratio tables.
// ----------------------------------------------------------------------------
package alvp_pkg;

  // Map count and label compare width
  localparam int NUM_MAPS   = 8;
  localparam int LABEL_BITS = 8;
  localparam int LABEL_W    = 8;
  localparam int CMP_BITS   = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int CNT_W      = $clog2(NUM_MAPS + 1);

  // Fixed-point formats
  localparam int VALUE_W  = 20;  // Q4.16 result
  localparam int MAXV_W   = 24;  // Q8.16 cap and normaliser
  localparam int LN_W     = 18;  // ln term, Q2.16
  localparam int FRAC_W   = 16;
  localparam int QUOT_W   = 17;  // quotient never exceeds 1.0
  localparam int NUM_W    = LN_W + FRAC_W;
  localparam int REM_W    = MAXV_W;
  localparam int DIV_STEPS = QUOT_W;

  localparam logic [VALUE_W-1:0] OUT_MAX = {VALUE_W{1'b1}};
  localparam logic [VALUE_W-1:0] ONE_Q16 = VALUE_W'(32'h0001_0000);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_LABEL_ID    = 2'd0,
    REG_OUTPUT_MODE = 2'd1,
    REG_MAX_VALUE   = 2'd2,
    REG_MAP_PRESENT = 2'd3
  } reg_idx_e;

  // Output mode codes; the spare code behaves as raw entropy
  localparam logic [1:0] MODE_PROB = 2'd0;
  localparam logic [1:0] MODE_NORM = 2'd1;
  localparam logic [1:0] MODE_RAW  = 2'd2;

  localparam logic [LABEL_W-1:0] LABEL_ID_RST    = 8'd1;
  localparam logic [1:0]         OUTPUT_MODE_RST = MODE_PROB;
  localparam logic [MAXV_W-1:0]  MAX_VALUE_RST   = 24'd6553600;
  localparam logic [7:0]         MAP_PRESENT_RST = 8'hFF;

  // One word in flight through the divider
  typedef struct packed {
    logic                use_div;
    logic [VALUE_W-1:0]  bypass;
    logic [MAXV_W-1:0]   divisor;
    logic [REM_W-1:0]    rem;
    logic [QUOT_W-1:0]   num_lo;
    logic [QUOT_W-1:0]   quot;
  } div_stage_t;

  // round(ln(n) * 65536) for n = 1..8
  function automatic logic [LN_W-1:0] ln_q16(input logic [3:0] n);
    logic [LN_W-1:0] v;
    unique case (n)
      4'd2:    v = 18'd45426;
      4'd3:    v = 18'd71999;
      4'd4:    v = 18'd90852;
      4'd5:    v = 18'd105476;
      4'd6:    v = 18'd117425;
      4'd7:    v = 18'd127527;
      4'd8:    v = 18'd136278;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round(a * 65536 / p), halves up, for 1 <= a <= p <= 8
  function automatic logic [QUOT_W-1:0] prob_q16(input logic [3:0] a, input logic [3:0] p);
    logic [QUOT_W-1:0] v;
    v = '0;
    unique case (p)
      4'd1: v = 17'd65536;
      4'd2: v = {a[1:0], 15'd0};
      4'd3: begin
        unique case (a)
          4'd1:    v = 17'd21845;
          4'd2:    v = 17'd43691;
          4'd3:    v = 17'd65536;
          default: v = '0;
        endcase
      end
      4'd4: v = {a[2:0], 14'd0};
      4'd5: begin
        unique case (a)
          4'd1:    v = 17'd13107;
          4'd2:    v = 17'd26214;
          4'd3:    v = 17'd39322;
          4'd4:    v = 17'd52429;
          4'd5:    v = 17'd65536;
          default: v = '0;
        endcase
      end
      4'd6: begin
        unique case (a)
          4'd1:    v = 17'd10923;
          4'd2:    v = 17'd21845;
          4'd3:    v = 17'd32768;
          4'd4:    v = 17'd43691;
          4'd5:    v = 17'd54613;
          4'd6:    v = 17'd65536;
          default: v = '0;
        endcase
      end
      4'd7: begin
        unique case (a)
          4'd1:    v = 17'd9362;
          4'd2:    v = 17'd18725;
          4'd3:    v = 17'd28087;
          4'd4:    v = 17'd37449;
          4'd5:    v = 17'd46811;
          4'd6:    v = 17'd56174;
          4'd7:    v = 17'd65536;
          default: v = '0;
        endcase
      end
      4'd8: v = {a, 13'd0};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/alvp_lane.sv -----
// ----------------------------------------------------------------------------
// alvp_lane: one label map lane
// Registers whether this map is present and whether its label matches the
// configured label ID on the compared low bits.
// ----------------------------------------------------------------------------
module alvp_lane (
  input  logic                        clk_i,
  input  logic [alvp_pkg::LABEL_W-1:0] label_i,
  input  logic [alvp_pkg::LABEL_W-1:0] label_id_i,
  input  logic                        present_i,
  output logic                        present_o,
  output logic                        agree_o
);

  logic present_q, agree_q;
  logic match;

  // Compare the low CMP_BITS label bits, here the full label width
  assign match = (label_i[alvp_pkg::CMP_BITS-1:0] == label_id_i[alvp_pkg::CMP_BITS-1:0]);

  // Capture the vote of this map
  always_ff @(posedge clk_i) begin
    present_q <= present_i;
    agree_q   <= present_i & match;
  end

  assign present_o = present_q;
  assign agree_o   = agree_q;

endmodule

// ----- hw/rtl/alvp_merge.sv -----
// ----------------------------------------------------------------------------
// alvp_merge: lane merge and mode selection
// Counts present and agreeing maps, forms the ln term, picks the result
// for every case that needs no division and prepares the divider word.
// ----------------------------------------------------------------------------
module alvp_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [alvp_pkg::NUM_MAPS-1:0]    present_i,
  input  logic [alvp_pkg::NUM_MAPS-1:0]    agree_i,
  input  logic [1:0]                       mode_i,
  input  logic [alvp_pkg::MAXV_W-1:0]      max_value_i,
  output logic                             valid_o,
  output alvp_pkg::div_stage_t             stage_o
);

  logic [alvp_pkg::CNT_W-1:0]   present_cnt, agree_cnt;
  logic [alvp_pkg::LN_W-1:0]    ln_term;
  logic [alvp_pkg::VALUE_W-1:0] max_sat;
  logic [alvp_pkg::NUM_W-1:0]   num;
  logic                         ln_ge;
  alvp_pkg::div_stage_t         stage_d, stage_q;
  logic                         valid_q;

  // Count the votes across the lanes
  always_comb begin
    present_cnt = '0;
    agree_cnt   = '0;
    for (int i = 0; i < alvp_pkg::NUM_MAPS; i++) begin
      present_cnt = present_cnt + alvp_pkg::CNT_W'(present_i[i]);
      agree_cnt   = agree_cnt + alvp_pkg::CNT_W'(agree_i[i]);
    end
  end

  // ln(present/agree) from the log table, zero without agreement
  always_comb begin
    ln_term = '0;
    if (agree_cnt != '0) begin
      ln_term = alvp_pkg::ln_q16(4'(present_cnt)) - alvp_pkg::ln_q16(4'(agree_cnt));
    end
  end

  assign ln_ge   = (alvp_pkg::MAXV_W'(ln_term) >= max_value_i);
  assign max_sat = (max_value_i[alvp_pkg::MAXV_W-1:alvp_pkg::VALUE_W] != '0)
                   ? alvp_pkg::OUT_MAX : max_value_i[alvp_pkg::VALUE_W-1:0];
  // Rounded dividend: ln * 2^16 + max / 2
  assign num     = {ln_term, {alvp_pkg::FRAC_W{1'b0}}}
                   + alvp_pkg::NUM_W'(max_value_i >> 1);

  // Select the result per mode and load the divider word
  always_comb begin
    stage_d.divisor = max_value_i;
    stage_d.rem     = alvp_pkg::REM_W'(num[alvp_pkg::NUM_W-1:alvp_pkg::QUOT_W]);
    stage_d.num_lo  = num[alvp_pkg::QUOT_W-1:0];
    stage_d.quot    = '0;
    stage_d.use_div = 1'b0;
    stage_d.bypass  = '0;
    priority if (mode_i == alvp_pkg::MODE_PROB) begin
      if (agree_cnt != '0) begin
        stage_d.bypass = alvp_pkg::VALUE_W'(
          alvp_pkg::prob_q16(4'(agree_cnt), 4'(present_cnt)));
      end
    end else if (mode_i == alvp_pkg::MODE_NORM) begin
      if ((agree_cnt == '0) || ln_ge) begin
        stage_d.bypass = alvp_pkg::ONE_Q16;
      end else begin
        stage_d.use_div = 1'b1;
      end
    end else begin
      stage_d.bypass = (agree_cnt == '0) ? max_sat : alvp_pkg::VALUE_W'(ln_term);
    end
  end

  // Hold the merged word for the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- hw/rtl/alvp_div.sv -----
// ----------------------------------------------------------------------------
// alvp_div: pipelined restoring divider
// One quotient bit per stage; words that need no division ride along with
// their result so every word leaves after the same number of stages.
// ----------------------------------------------------------------------------
module alvp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  alvp_pkg::div_stage_t         stage_i,
  output logic                         valid_o,
  output logic [alvp_pkg::VALUE_W-1:0] value_o
);

  logic                 valid_q [alvp_pkg::DIV_STEPS];
  alvp_pkg::div_stage_t stage_q [alvp_pkg::DIV_STEPS];

  // One restoring step: shift in a dividend bit, subtract if it fits
  function automatic alvp_pkg::div_stage_t div_step(input alvp_pkg::div_stage_t s);
    alvp_pkg::div_stage_t  r;
    logic [alvp_pkg::REM_W:0] trial;
    logic [alvp_pkg::REM_W:0] dvs;
    logic                  fits;
    r     = s;
    trial = {s.rem, s.num_lo[alvp_pkg::QUOT_W-1]};
    dvs   = {1'b0, s.divisor};
    fits  = (trial >= dvs);
    r.rem    = fits ? alvp_pkg::REM_W'(trial - dvs) : trial[alvp_pkg::REM_W-1:0];
    r.num_lo = {s.num_lo[alvp_pkg::QUOT_W-2:0], 1'b0};
    r.quot   = {s.quot[alvp_pkg::QUOT_W-2:0], fits};
    return r;
  endfunction

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < alvp_pkg::DIV_STEPS; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < alvp_pkg::DIV_STEPS; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // Advance the words, one quotient bit per stage
  always_ff @(posedge clk_i) begin
    stage_q[0] <= div_step(stage_i);
    for (int s = 1; s < alvp_pkg::DIV_STEPS; s++) begin
      stage_q[s] <= div_step(stage_q[s-1]);
    end
  end

  assign valid_o = valid_q[alvp_pkg::DIV_STEPS-1];
  assign value_o = stage_q[alvp_pkg::DIV_STEPS-1].use_div
                   ? alvp_pkg::VALUE_W'(stage_q[alvp_pkg::DIV_STEPS-1].quot)
                   : stage_q[alvp_pkg::DIV_STEPS-1].bypass;

endmodule

// ----- hw/rtl/atlas_label_vote_probability.sv -----
// ----------------------------------------------------------------------------
// atlas_label_vote_probability: per-voxel label vote probability and entropy
// Path: the lane registers, the merge register, the divider stages, then done_o.
// Throughput: one voxel word per cycle; busy is never raised, the lanes,
// the merge stage and the 17-stage divider are all fully pipelined.
// Reset: rst_ni clears the pipeline flags and loads the register defaults.
// ----------------------------------------------------------------------------
module atlas_label_vote_probability (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_0_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_1_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_2_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_3_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_4_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_5_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_6_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_7_i,
  output logic                                 done_o,
  output logic [alvp_pkg::VALUE_W-1:0]         voxel_value_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [alvp_pkg::PADDR_W-1:0]         paddr,
  input  logic [alvp_pkg::PDATA_W-1:0]         pwdata,
  output logic [alvp_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  logic [alvp_pkg::LABEL_W-1:0] label_id_q;
  logic [1:0]                   output_mode_q;
  logic [alvp_pkg::MAXV_W-1:0]  max_value_q;
  logic [7:0]                   map_present_q;
  logic                         cfg_wr;
  alvp_pkg::reg_idx_e           reg_idx;

  logic [alvp_pkg::LABEL_W-1:0] labels [8];
  logic [alvp_pkg::NUM_MAPS-1:0] lane_present, lane_agree;
  logic                         lane_valid_q;
  logic                         merge_valid;
  alvp_pkg::div_stage_t         merge_stage;
  logic                         div_valid;
  logic [alvp_pkg::VALUE_W-1:0] div_value;
  logic                         done_q;
  logic [alvp_pkg::VALUE_W-1:0] voxel_value_q;

  // Configuration port
  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = alvp_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_id_q    <= alvp_pkg::LABEL_ID_RST;
      output_mode_q <= alvp_pkg::OUTPUT_MODE_RST;
      max_value_q   <= alvp_pkg::MAX_VALUE_RST;
      map_present_q <= alvp_pkg::MAP_PRESENT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        alvp_pkg::REG_LABEL_ID:    label_id_q    <= pwdata[alvp_pkg::LABEL_W-1:0];
        alvp_pkg::REG_OUTPUT_MODE: output_mode_q <= pwdata[1:0];
        alvp_pkg::REG_MAX_VALUE:   max_value_q   <= pwdata[alvp_pkg::MAXV_W-1:0];
        alvp_pkg::REG_MAP_PRESENT: map_present_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      alvp_pkg::REG_LABEL_ID:    prdata = alvp_pkg::PDATA_W'(label_id_q);
      alvp_pkg::REG_OUTPUT_MODE: prdata = alvp_pkg::PDATA_W'(output_mode_q);
      alvp_pkg::REG_MAX_VALUE:   prdata = alvp_pkg::PDATA_W'(max_value_q);
      alvp_pkg::REG_MAP_PRESENT: prdata = alvp_pkg::PDATA_W'(map_present_q);
      default:                   prdata = '0;
    endcase
  end

  // Gather the labels
  assign labels[0] = label_0_i;
  assign labels[1] = label_1_i;
  assign labels[2] = label_2_i;
  assign labels[3] = label_3_i;
  assign labels[4] = label_4_i;
  assign labels[5] = label_5_i;
  assign labels[6] = label_6_i;
  assign labels[7] = label_7_i;

  // One lane per label map
  for (genvar g = 0; g < alvp_pkg::NUM_MAPS; g++) begin : g_lane
    alvp_lane u_lane (
      .clk_i      (clk_i),
      .label_i    (labels[g]),
      .label_id_i (label_id_q),
      .present_i  (map_present_q[g]),
      .present_o  (lane_present[g]),
      .agree_o    (lane_agree[g])
    );
  end

  // Track a word in the lane stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else begin
      lane_valid_q <= start & ~busy;
    end
  end

  alvp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (lane_valid_q),
    .present_i   (lane_present),
    .agree_i     (lane_agree),
    .mode_i      (output_mode_q),
    .max_value_i (max_value_q),
    .valid_o     (merge_valid),
    .stage_o     (merge_stage)
  );

  alvp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (merge_valid),
    .stage_i (merge_stage),
    .valid_o (div_valid),
    .value_o (div_value)
  );

  // Present each result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    voxel_value_q <= div_value;
  end

  assign done_o        = done_q;
  assign voxel_value_o = voxel_value_q;

endmodule

// ----- hw/rtl/alvp_checker.sv -----
// ----------------------------------------------------------------------------
// alvp_checker: port-level checks for the label vote block
// Watches start, done and the configuration port and is bound to the top.
// ----------------------------------------------------------------------------
module alvp_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_0_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_1_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_2_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_3_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_4_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_5_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_6_i,
  input  logic [alvp_pkg::LABEL_W-1:0]         label_7_i,
  input  logic                                 done_o,
  input  logic [alvp_pkg::VALUE_W-1:0]         voxel_value_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [alvp_pkg::PADDR_W-1:0]         paddr,
  input  logic [alvp_pkg::PDATA_W-1:0]         pwdata,
  input  logic [alvp_pkg::PDATA_W-1:0]         prdata,
  input  logic                                 pready
);

  // Every accepted word gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##20 done_o)
    else $error("accepted word gave no result");

  // No result appears without a word accepted earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##20 !done_o)
    else $error("result without an accepted word");

  // The first edge after reset shows no result
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !done_o)
    else $error("result straight after reset");

  // A label ID write reads back masked to its width
  a_label_id_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((psel && penable && pwrite && pready && paddr[3:2] == alvp_pkg::REG_LABEL_ID)
      ##1 (psel && !pwrite && paddr[3:2] == alvp_pkg::REG_LABEL_ID))
    |-> prdata == {24'd0, $past(pwdata[alvp_pkg::LABEL_W-1:0])})
    else $error("label ID read back wrong");

endmodule

bind atlas_label_vote_probability alvp_checker u_alvp_checker (.*);

// ----- test/alvp_vote_checker.sv -----
// ----------------------------------------------------------------------------
// alvp_vote_checker: result predictor and scoreboard for the label vote block
// Tracks the register writes on the APB port, predicts the voxel value of
// every accepted voxel word, and compares each returned word in order.
// ----------------------------------------------------------------------------
module alvp_vote_checker
  import alvp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic [LABEL_W-1:0]  label_0_i,
  input  logic [LABEL_W-1:0]  label_1_i,
  input  logic [LABEL_W-1:0]  label_2_i,
  input  logic [LABEL_W-1:0]  label_3_i,
  input  logic [LABEL_W-1:0]  label_4_i,
  input  logic [LABEL_W-1:0]  label_5_i,
  input  logic [LABEL_W-1:0]  label_6_i,
  input  logic [LABEL_W-1:0]  label_7_i,
  input  logic                done_o,
  input  logic [VALUE_W-1:0]  voxel_value_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic                pready,
  output int                  mismatch_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NUM_MAPS-1:0][LABEL_W-1:0] voxel_t;

  // Shadow copy of the configuration registers
  logic [LABEL_W-1:0] label_id_q;
  logic [1:0]         output_mode_q;
  logic [MAXV_W-1:0]  max_value_q;
  logic [7:0]         map_present_q;

  logic [VALUE_W-1:0] pending_values [$];

  // Natural log of a map count in Q2.16
  function automatic logic [63:0] log_count(input int unsigned n);
    case (n)
      2:       return 64'd45426;
      3:       return 64'd71999;
      4:       return 64'd90852;
      5:       return 64'd105476;
      6:       return 64'd117425;
      7:       return 64'd127527;
      8:       return 64'd136278;
      default: return 64'd0;
    endcase
  endfunction

  // Vote count, then probability or entropy term of one voxel
  function automatic logic [VALUE_W-1:0] vote_value(input voxel_t vox);
    int unsigned present;
    int unsigned agree;
    logic [63:0] ln_term;
    logic [63:0] value;
    present = 0;
    agree   = 0;
    for (int m = 0; m < NUM_MAPS; m++) begin
      if (map_present_q[m]) begin
        present++;
        if (vox[m][CMP_BITS-1:0] == label_id_q[CMP_BITS-1:0]) agree++;
      end
    end
    ln_term = (agree != 0) ? log_count(present) - log_count(agree) : 64'd0;
    case (output_mode_q)
      MODE_PROB: begin
        if (agree == 0) value = 0;
        else value = (64'(agree) * 65536 + present / 2) / present;
      end
      MODE_NORM: begin
        // no agreement or a term at the cap reads as 1.0
        if (agree == 0 || ln_term >= max_value_q) value = 64'd65536;
        else value = (ln_term * 65536 + max_value_q / 2) / max_value_q;
      end
      default: begin
        // raw entropy, the spare code too; saturate to the output range
        value = (agree == 0) ? 64'(max_value_q) : ln_term;
        if (value > 64'(OUT_MAX)) value = 64'(OUT_MAX);
      end
    endcase
    return value[VALUE_W-1:0];
  endfunction

  // Follow register writes, queue predictions, compare returned words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_id_q       = LABEL_ID_RST;
      output_mode_q    = OUTPUT_MODE_RST;
      max_value_q      = MAX_VALUE_RST;
      map_present_q    = MAP_PRESENT_RST;
      mismatch_count_o = 0;
      pending_values.delete();
      pending_o        = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_LABEL_ID:    label_id_q    = pwdata[LABEL_W-1:0];
          REG_OUTPUT_MODE: output_mode_q = pwdata[1:0];
          REG_MAX_VALUE:   max_value_q   = pwdata[MAXV_W-1:0];
          REG_MAP_PRESENT: map_present_q = pwdata[7:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        pending_values.push_back(vote_value({label_7_i, label_6_i, label_5_i, label_4_i,
                                             label_3_i, label_2_i, label_1_i, label_0_i}));
      end
      if (done_o) begin
        if (pending_values.size() == 0) begin
          $display("%0t: unexpected voxel word: expected none, got %0d",
                   $time, voxel_value_o);
          mismatch_count_o++;
        end else begin
          if (voxel_value_o !== pending_values[0]) begin
            $display("%0t: voxel_value mismatch: expected %0d, got %0d",
                     $time, pending_values[0], voxel_value_o);
            mismatch_count_o++;
          end
          void'(pending_values.pop_front());
        end
      end
      pending_o = pending_values.size();
    end
  end

endmodule

// ----- test/atlas_label_vote_probability_tb.sv -----
// ----------------------------------------------------------------------------
// atlas_label_vote_probability_tb: stimulus and verdict for the label vote block
// Drives directed and random voxel words through several register settings,
// with random sender gaps, and lets the checker score every returned word.
// ----------------------------------------------------------------------------
module atlas_label_vote_probability_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alvp_pkg::*;

  localparam int         CLK_PERIOD  = 10;
  localparam int         STALL_LIMIT = 1000;
  localparam int         FLUSH_WAIT  = 25;
  localparam int         BLOCK_ITEMS = 115;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef logic [NUM_MAPS-1:0][LABEL_W-1:0] voxel_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  voxel_t             labels;
  logic               done_o;
  logic [VALUE_W-1:0] voxel_value_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 mismatch_count;
  int                 pending;
  int                 sender_idle_pct;
  int                 stall_cycles;
  logic [LABEL_W-1:0] cur_label;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  atlas_label_vote_probability dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .label_0_i     (labels[0]),
    .label_1_i     (labels[1]),
    .label_2_i     (labels[2]),
    .label_3_i     (labels[3]),
    .label_4_i     (labels[4]),
    .label_5_i     (labels[5]),
    .label_6_i     (labels[6]),
    .label_7_i     (labels[7]),
    .done_o        (done_o),
    .voxel_value_o (voxel_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  alvp_vote_checker vote_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .label_0_i        (labels[0]),
    .label_1_i        (labels[1]),
    .label_2_i        (labels[2]),
    .label_3_i        (labels[3]),
    .label_4_i        (labels[4]),
    .label_5_i        (labels[5]),
    .label_6_i        (labels[6]),
    .label_7_i        (labels[7]),
    .done_o           (done_o),
    .voxel_value_o    (voxel_value_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Abort when nothing moves for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || done_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Voxel whose maps flagged in votes carry the label, the rest another one
  function automatic voxel_t voxel_with_votes(input logic [LABEL_W-1:0] label,
                                              input logic [NUM_MAPS-1:0] votes);
    voxel_t vox;
    for (int m = 0; m < NUM_MAPS; m++) begin
      vox[m] = votes[m] ? label : label ^ LABEL_W'($urandom_range(1, 255));
    end
    return vox;
  endfunction

  // Offer one voxel word, after a random gap, and hold it until taken
  task automatic send_voxel(input voxel_t vox);
    logic free;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start  <= 1'b0;
      labels <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    start  <= 1'b1;
    labels <= vox;
    do begin
      @(negedge clk_i);
      free = !busy;
      @(posedge clk_i);
    end while (!free);
  endtask

  // Stop offering words until every prediction has been matched
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access until pready
  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Rewrite every register once the block is idle
  task automatic configure(input logic [LABEL_W-1:0] label, input logic [1:0] mode,
                           input logic [MAXV_W-1:0] maxv, input logic [7:0] mask);
    drain();
    write_reg(REG_LABEL_ID, PDATA_W'(label));
    write_reg(REG_OUTPUT_MODE, PDATA_W'(mode));
    write_reg(REG_MAX_VALUE, PDATA_W'(maxv));
    write_reg(REG_MAP_PRESENT, PDATA_W'(mask));
    cur_label = label;
  endtask

  // Random setting, weighted towards the extremes
  task automatic random_config;
    logic [LABEL_W-1:0] label;
    logic [MAXV_W-1:0]  maxv;
    logic [7:0]         mask;
    case ($urandom_range(0, 5))
      0:       label = '0;
      1:       label = '1;
      default: label = LABEL_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       maxv = '0;
      1:       maxv = MAXV_W'(1);
      2:       maxv = '1;
      3:       maxv = MAXV_W'($urandom_range(1, 200000));
      4:       maxv = MAXV_W'($urandom_range(60000, 140000));
      default: maxv = MAXV_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       mask = 8'hFF;
      1:       mask = 8'h00;
      2:       mask = 8'(1 << $urandom_range(0, 7));
      default: mask = 8'($urandom);
    endcase
    configure(label, 2'($urandom_range(0, 3)), maxv, mask);
  endtask

  // Mostly voxels with a random vote pattern, some pure noise
  task automatic random_block(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0) send_voxel(voxel_with_votes(cur_label, 8'($urandom)));
      else send_voxel({$urandom, $urandom});
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    labels          = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sender_idle_pct = 0;
    cur_label       = LABEL_ID_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: probability over all eight maps
    send_voxel('0);
    send_voxel({NUM_MAPS{LABEL_ID_RST}});
    send_voxel('1);
    send_voxel(voxel_with_votes(LABEL_ID_RST, 8'b1010_1010));
    send_voxel(voxel_with_votes(LABEL_ID_RST, 8'b0000_0100));

    // Normalised, single map present, widest cap
    configure(8'hFF, MODE_NORM, '1, 8'h80);
    send_voxel('1);
    send_voxel('0);

    // Normalised with the smallest cap: a lone vote reaches it, full agreement does not
    configure(8'h00, MODE_NORM, MAXV_W'(1), 8'hFF);
    send_voxel(voxel_with_votes(8'h00, 8'b0001_0000));
    send_voxel('0);

    // Raw, no map present: saturated cap
    configure(8'h00, MODE_RAW, '1, 8'h00);
    send_voxel('0);

    // Spare mode code with a zero cap
    configure(8'h00, MODE_SPARE, '0, 8'h0F);
    send_voxel('1);
    send_voxel(voxel_with_votes(8'h00, 8'b0000_0001));

    // Normalised with a zero cap: always 1.0
    configure(8'h5A, MODE_NORM, '0, 8'hFF);
    send_voxel(voxel_with_votes(8'h5A, 8'b0100_0101));
    send_voxel(voxel_with_votes(8'h5A, 8'h00));

    // Probability over seven and six maps for the rounding
    configure(8'hA5, MODE_PROB, MAX_VALUE_RST, 8'h7F);
    send_voxel(voxel_with_votes(8'hA5, 8'b0011_0001));
    send_voxel(voxel_with_votes(8'hA5, 8'b0000_0010));
    configure(8'hA5, MODE_PROB, MAX_VALUE_RST, 8'h3F);
    send_voxel(voxel_with_votes(8'hA5, 8'b0010_0000));
    send_voxel(voxel_with_votes(8'hA5, 8'b0001_1011));

    // Random settings under three sender gap profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sender_idle_pct = 22;
        1:       sender_idle_pct = 67;
        default: sender_idle_pct = 0;
      endcase
      repeat (4) begin
        random_config();
        random_block(BLOCK_ITEMS);
      end
    end

    // Let the pipeline empty, then give the verdict
    drain();
    repeat (FLUSH_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
